[src/multi_channel_mailbox_defines.svh]
// ----------------------------------------------------------------------------
// multi_channel_mailbox assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_MAILBOX_DEFINES_SVH
`define MULTI_CHANNEL_MAILBOX_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define MCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mailbox check failed");
// condition never holds
`define MCM_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("mailbox check failed");
`else
`define MCM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MCM_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[src/mcm_pkg.sv]
// ----------------------------------------------------------------------------
// mcm_pkg
// Types and defaults shared by the multi channel mailbox modules.
// ----------------------------------------------------------------------------
package mcm_pkg;

	localparam int DEF_NUM_CHANNELS = 4;
	localparam int DEF_QUEUE_DEPTH  = 16;
	localparam int DEF_MAX_PENDING  = 15;

	typedef enum logic {
		MODE_SEND = 1'b0,
		MODE_RECV = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_DELIVERED   = 2'd0,
		ST_BAD_CHANNEL = 2'd1,
		ST_QUEUE_FULL  = 2'd2,
		ST_PEND_OVF    = 2'd3
	} status_t;

	typedef struct packed {
		mode_t      mode;
		logic [3:0] channel;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] channel_res;
		logic [7:0] message;
	} res_t;

	// store access issued by the control stage
	typedef struct packed {
		logic       wr;
		logic       rd;
		logic [7:0] wdata;
	} mem_req_t;

	// result beat under construction, message may still come from the store
	typedef struct packed {
		logic valid;
		logic from_mem;
		res_t res;
	} res_ctl_t;

endpackage

[src/mcm_store.sv]
// ----------------------------------------------------------------------------
// mcm_store
// Shared message memory, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module mcm_store import mcm_pkg::*; #(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
	localparam int DEPTH  = NUM_CHANNELS * QUEUE_DEPTH,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  mem_req_t          req,
	input  logic [ADDR_W-1:0] addr,
	output logic [7:0]        rd_data_s2
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[addr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rd_data_s2 <= mem_q[addr];
		end
	end

endmodule

[src/mcm_ctrl.sv]
// ----------------------------------------------------------------------------
// mcm_ctrl
// Per channel pointers, fill and pending counters, and the decision for one
// command beat; issues the store access and registers the result control.
// ----------------------------------------------------------------------------
module mcm_ctrl import mcm_pkg::*; #(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
	parameter int MAX_PENDING  = DEF_MAX_PENDING,
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
	localparam int PTR_W  = $clog2(QUEUE_DEPTH),
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
	localparam int PEND_W = $clog2(MAX_PENDING + 1),
	localparam int ADDR_W = $clog2(NUM_CHANNELS * QUEUE_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  cmd_t              cmd_s1,
	output mem_req_t          mem_req,
	output logic [ADDR_W-1:0] mem_addr,
	output res_ctl_t          res_ctl_s2
);

	logic [PTR_W-1:0]  rd_ptr_q  [NUM_CHANNELS];
	logic [PTR_W-1:0]  wr_ptr_q  [NUM_CHANNELS];
	logic [CNT_W-1:0]  fill_q    [NUM_CHANNELS];
	logic [PEND_W-1:0] pend_q    [NUM_CHANNELS];

	logic              chan_ok;
	logic [CH_W-1:0]   ch;
	logic [PTR_W-1:0]  rd_ptr;
	logic [PTR_W-1:0]  wr_ptr;
	logic [CNT_W-1:0]  fill;
	logic [PEND_W-1:0] pend;
	logic              do_push;
	logic              do_pop;
	logic              do_pend_inc;
	logic              do_pend_dec;
	res_ctl_t          res_ctl;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	assign chan_ok = (5'(cmd_s1.channel) < 5'(NUM_CHANNELS));
	assign ch      = cmd_s1.channel[CH_W-1:0];
	assign rd_ptr  = rd_ptr_q[ch];
	assign wr_ptr  = wr_ptr_q[ch];
	assign fill    = fill_q[ch];
	assign pend    = pend_q[ch];

	always_comb begin
		do_push     = 1'b0;
		do_pop      = 1'b0;
		do_pend_inc = 1'b0;
		do_pend_dec = 1'b0;
		res_ctl.valid           = 1'b0;
		res_ctl.from_mem        = 1'b0;
		res_ctl.res.status      = ST_DELIVERED;
		res_ctl.res.channel_res = cmd_s1.channel;
		res_ctl.res.message     = '0;
		if (valid_s1) begin
			if (!chan_ok) begin
				res_ctl.valid      = 1'b1;
				res_ctl.res.status = ST_BAD_CHANNEL;
			end else if (cmd_s1.mode == MODE_SEND) begin
				if (pend != '0) begin
					do_pend_dec         = 1'b1;
					res_ctl.valid       = 1'b1;
					res_ctl.res.message = cmd_s1.data;
				end else if (fill == CNT_W'(QUEUE_DEPTH)) begin
					res_ctl.valid      = 1'b1;
					res_ctl.res.status = ST_QUEUE_FULL;
				end else begin
					do_push = 1'b1;
				end
			end else begin
				if (fill != '0) begin
					do_pop           = 1'b1;
					res_ctl.valid    = 1'b1;
					res_ctl.from_mem = 1'b1;
				end else if (pend == PEND_W'(MAX_PENDING)) begin
					res_ctl.valid      = 1'b1;
					res_ctl.res.status = ST_PEND_OVF;
				end else begin
					do_pend_inc = 1'b1;
				end
			end
		end
	end

	assign mem_req.wr    = do_push;
	assign mem_req.rd    = do_pop;
	assign mem_req.wdata = cmd_s1.data;
	assign mem_addr      = ADDR_W'(ch) * ADDR_W'(QUEUE_DEPTH)
		+ ADDR_W'(do_push ? wr_ptr : rd_ptr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				fill_q[i]   <= '0;
				pend_q[i]   <= '0;
			end
		end else begin
			if (do_push) begin
				wr_ptr_q[ch] <= ptr_inc(wr_ptr);
				fill_q[ch]   <= fill + CNT_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q[ch] <= ptr_inc(rd_ptr);
				fill_q[ch]   <= fill - CNT_W'(1);
			end
			if (do_pend_inc) begin
				pend_q[ch] <= pend + PEND_W'(1);
			end
			if (do_pend_dec) begin
				pend_q[ch] <= pend - PEND_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ctl_s2 <= '0;
		end else begin
			res_ctl_s2 <= res_ctl;
		end
	end

endmodule

[src/multi_channel_mailbox.sv]
// ----------------------------------------------------------------------------
// multi_channel_mailbox
// Per channel byte queues in one shared store, with pending receive counts.
//
//   port   dir  handshake           payload
//   cmd    in   start high, !busy   mode, channel, data
//   res    out  done strobe         status, channel_res, message
//
// A command beat can be taken in every cycle; busy stays low.
// The result of a beat, if any, reaches res through the command register
// and then the registered result control and registered read of the message store.
// Reset clears pointers and counters at once; no clearing pass is needed.
// The receiver cannot stall, so done is a one cycle strobe.
// ----------------------------------------------------------------------------
`include "multi_channel_mailbox_defines.svh"

module multi_channel_mailbox import mcm_pkg::*; #(
	parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
	parameter int MAX_PENDING  = DEF_MAX_PENDING,
	localparam int ADDR_W = $clog2(NUM_CHANNELS * QUEUE_DEPTH)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t res
);

	logic              valid_s1;
	cmd_t              cmd_s1;
	mem_req_t          mem_req;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        rd_data_s2;
	res_ctl_t          res_ctl_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	mcm_ctrl #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_PENDING (MAX_PENDING)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.cmd_s1    (cmd_s1),
		.mem_req   (mem_req),
		.mem_addr  (mem_addr),
		.res_ctl_s2(res_ctl_s2)
	);

	mcm_store #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk       (clk),
		.req       (mem_req),
		.addr      (mem_addr),
		.rd_data_s2(rd_data_s2)
	);

	assign done            = res_ctl_s2.valid;
	assign res.status      = res_ctl_s2.res.status;
	assign res.channel_res = res_ctl_s2.res.channel_res;
	assign res.message     = res_ctl_s2.from_mem ? rd_data_s2 : res_ctl_s2.res.message;

	`MCM_ASSERT_IMP(a_done_follows_beat, clk, arst_n, done, $past(valid_s1))
	`MCM_ASSERT_IMP(a_msg_zero_on_error, clk, arst_n,
		done && (res.status != ST_DELIVERED), res.message == 8'd0)
	`MCM_ASSERT_IMP(a_bad_channel, clk, arst_n,
		done && (5'(res.channel_res) >= 5'(NUM_CHANNELS)), res.status == ST_BAD_CHANNEL)
	`MCM_ASSERT_NEVER(a_store_single_access, clk, arst_n, mem_req.wr && mem_req.rd)

endmodule

[test/multi_channel_mailbox_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_mailbox_tb
// Drives send and receive beats into the mailbox and tracks every channel's
// queue, read and write pointers, fill level and pending receive count. The
// tracker predicts each result beat, and every done strobe is compared with
// the oldest prediction. A directed opening is followed by bursts of sends and
// receives on one channel, mixed single beats and noise. The run uses three
// sender idling profiles.
// ----------------------------------------------------------------------------
module multi_channel_mailbox_tb;
	import mcm_pkg::*;

	localparam int NCH        = DEF_NUM_CHANNELS;
	localparam int QD         = DEF_QUEUE_DEPTH;
	localparam int MAXP       = DEF_MAX_PENDING;
	localparam int STALL_LIMIT = 1000;

	class chan_fifo_tracker;
		logic [7:0] store [NCH*QD];
		logic [3:0] rd_ptr [NCH];
		logic [3:0] wr_ptr [NCH];
		logic [4:0] fill [NCH];
		logic [3:0] pend [NCH];
		res_t       due_results [$];
		int         mismatches;

		function new();
			for (int i = 0; i < NCH; i++) begin
				rd_ptr[i] = '0;
				wr_ptr[i] = '0;
				fill[i]   = '0;
				pend[i]   = '0;
			end
			mismatches = 0;
		endfunction

		function void take_cmd(cmd_t c);
			res_t r;
			int   ch;
			bit   has_res;
			ch            = c.channel;
			r.status      = ST_DELIVERED;
			r.channel_res = c.channel;
			r.message     = 8'h00;
			has_res       = 1'b1;
			if (ch >= NCH) begin
				r.status = ST_BAD_CHANNEL;
			end else if (c.mode == MODE_SEND) begin
				if (pend[ch] > 0) begin
					pend[ch]  = 4'(pend[ch] - 1);
					r.message = c.data;
				end else if (fill[ch] >= QD) begin
					r.status = ST_QUEUE_FULL;
				end else begin
					store[ch*QD + wr_ptr[ch]] = c.data;
					wr_ptr[ch] = 4'((wr_ptr[ch] + 1) % QD);
					fill[ch]   = 5'(fill[ch] + 1);
					has_res    = 1'b0;
				end
			end else begin
				if (fill[ch] > 0) begin
					r.message  = store[ch*QD + rd_ptr[ch]];
					rd_ptr[ch] = 4'((rd_ptr[ch] + 1) % QD);
					fill[ch]   = 5'(fill[ch] - 1);
				end else if (pend[ch] >= MAXP) begin
					r.status = ST_PEND_OVF;
				end else begin
					pend[ch] = 4'(pend[ch] + 1);
					has_res  = 1'b0;
				end
			end
			if (has_res)
				due_results = {due_results, r};
		endfunction

		function void match_res(res_t r);
			res_t e;
			if (due_results.size() == 0) begin
				$error("unexpected result beat: status %0d channel %0d message %0h",
					r.status, r.channel_res, r.message);
				mismatches++;
				return;
			end
			e = due_results.pop_front();
			if (r.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, r.status);
				mismatches++;
			end
			if (r.channel_res !== e.channel_res) begin
				$error("channel_res: expected %0d, actual %0d", e.channel_res, r.channel_res);
				mismatches++;
			end
			if (r.message !== e.message) begin
				$error("message: expected %0h, actual %0h", e.message, r.message);
				mismatches++;
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic done;
	res_t res;

	chan_fifo_tracker sb = new();
	int sender_idle_pct = 16;
	int stall_cycles    = 0;

	multi_channel_mailbox dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				sb.match_res(res);
			if (start && busy === 1'b0)
				sb.take_cmd(cmd);
			if ((start && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic cmd_t make_cmd(mode_t m, int ch, int d);
		cmd_t c;
		c.mode    = m;
		c.channel = ch[3:0];
		c.data    = d[7:0];
		return c;
	endfunction

	function automatic cmd_t noise_cmd();
		return make_cmd(mode_t'($urandom_range(1)), $urandom_range(15), $urandom_range(255));
	endfunction

	// one command beat, with an optional idle gap in front
	task automatic drive_beat(cmd_t c);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			cmd   <= noise_cmd();
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic burst(mode_t m, int ch, int len);
		for (int i = 0; i < len; i++)
			drive_beat(make_cmd(m, ch, $urandom_range(255)));
	endtask

	task automatic run_random(int n);
		int issued;
		int kind;
		int ch;
		int len;
		issued = 0;
		while (issued < n) begin
			kind = $urandom_range(99);
			ch   = $urandom_range(NCH - 1);
			len  = $urandom_range(1, 20);
			if (kind < 40) begin
				burst(MODE_SEND, ch, len);
				issued += len;
			end else if (kind < 70) begin
				burst(MODE_RECV, ch, len);
				issued += len;
			end else if (kind < 90) begin
				drive_beat(make_cmd(mode_t'($urandom_range(1)), ch, $urandom_range(255)));
				issued++;
			end else begin
				drive_beat(noise_cmd());
				issued++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		drive_beat(make_cmd(MODE_SEND, 0, 8'h00));
		drive_beat(make_cmd(MODE_SEND, 0, 8'hFF));
		drive_beat(make_cmd(MODE_RECV, 0, 8'h00));
		drive_beat(make_cmd(MODE_RECV, 0, 8'hFF));
		// empty queue, receives wait
		drive_beat(make_cmd(MODE_RECV, 0, 8'h11));
		drive_beat(make_cmd(MODE_RECV, 0, 8'h22));
		drive_beat(make_cmd(MODE_SEND, 0, 8'h5A));
		drive_beat(make_cmd(MODE_SEND, 0, 8'hA5));
		drive_beat(make_cmd(MODE_SEND, 0, 8'h3C));
		drive_beat(make_cmd(MODE_RECV, 0, 8'h00));
		drive_beat(make_cmd(MODE_SEND, 3, 8'h81));
		drive_beat(make_cmd(MODE_RECV, 3, 8'h00));
		// invalid channels, then beats on valid channels 1 and 2
		drive_beat(make_cmd(MODE_SEND, 4, 8'hFF));
		drive_beat(make_cmd(MODE_RECV, 4, 8'h00));
		drive_beat(make_cmd(MODE_SEND, 15, 8'h00));
		drive_beat(make_cmd(MODE_RECV, 15, 8'hFF));
		drive_beat(make_cmd(MODE_SEND, 8, 8'h7F));
		drive_beat(make_cmd(MODE_RECV, 1, 8'h00));
		drive_beat(make_cmd(MODE_SEND, 2, 8'h01));
		drive_beat(make_cmd(MODE_SEND, 1, 8'h80));
		drive_beat(make_cmd(MODE_RECV, 2, 8'h00));

		// full queue then pending overflow
		burst(MODE_SEND, 2, QD + 2);
		burst(MODE_RECV, 2, QD);
		burst(MODE_RECV, 1, MAXP + 2);
		burst(MODE_SEND, 1, MAXP + 1);

		sender_idle_pct = 16;
		run_random(185);
		sender_idle_pct = 79;
		run_random(185);
		sender_idle_pct = 0;
		run_random(185);

		start <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.due_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
